@@ rtl/assembly_text_tokenizer_unit_defines.svh @@
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSEMBLY_TEXT_TOKENIZER_UNIT_DEFINES_SVH
`define ASSEMBLY_TEXT_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ATT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ATT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/att_pkg.sv @@
// Shared types and constants of the assembly text tokenizer.
// No dependencies; imported by every tokenizer module.
`timescale 1ns / 1ps

package att_pkg;

    localparam int NAME_LIMIT  = 31;
    localparam int LEN_W       = $clog2(NAME_LIMIT + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

    typedef enum logic [3:0] {
        KIND_NAME_CHAR   = 4'd0,
        KIND_NAME_END    = 4'd1,
        KIND_NUMBER      = 4'd2,
        KIND_COLON       = 4'd3,
        KIND_STRING_CHAR = 4'd4,
        KIND_STRING_END  = 4'd5,
        KIND_EQUALS      = 4'd6,
        KIND_OPEN        = 4'd7,
        KIND_CLOSE       = 4'd8,
        KIND_NEWLINE     = 4'd9,
        KIND_END         = 4'd10,
        KIND_ERROR       = 4'd11
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [23:0] line;
    } tok_t;

    // one or two tokens caused by a single input request
    typedef struct packed {
        logic two;
        tok_t first;
        tok_t second;
    } bundle_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

@@ rtl/assembly_text_tokenizer_unit.sv @@
// Top level of the assembly text tokenizer: lexer, bundle queue, emitter.
// Depends on att_pkg, att_lexer, att_queue and att_emitter.
//
// Usage:
//   Slave channel: one request per text byte, s_tdata[7:0] = byte_in,
//   s_tuser = end_of_input (byte ignored when set).
//   Master channel: one token per beat, m_tuser = token_kind,
//   m_tdata = token_value and line_number, m_tlast marks the last token
//   caused by one request. A request yields zero, one or two tokens.
//   Throughput: one request per cycle while the four-entry bundle queue
//   has room; the output side moves one token per cycle while m_tready
//   is high, so a run of two-token requests is paced by the master port.
//   Each accepted bundle goes into the queue, then its first token into
//   the m_* output register; a second token waits until the first is taken.
//   A stalled master fills the queue, after which s_tready drops; nothing
//   is lost or reordered.
//   Reset (aresetn low, synchronous) clears lexer state, sets the line
//   count to one and empties the queue. After an error or end token the
//   block swallows all further requests until the next reset.
`timescale 1ns / 1ps

module assembly_text_tokenizer_unit import att_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] token_value, [55:32] line_number
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast
);

    logic      push;
    bundle_t   push_bundle;
    logic      pop;
    bundle_t   head;
    q_status_t q_status;

    assign s_tready = !q_status.full;

    att_lexer u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_eoi      (s_tuser),
        .push        (push),
        .push_bundle (push_bundle)
    );

    att_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head        (head),
        .status      (q_status)
    );

    att_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/att_lexer.sv @@
// Front end: accepts text bytes, tracks lexer state, builds token bundles.
// Depends on att_pkg and the tokenizer assertion macros.
`timescale 1ns / 1ps
`include "assembly_text_tokenizer_unit_defines.svh"

module att_lexer import att_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_eoi,
    output logic        push,
    output bundle_t     push_bundle
);

    typedef enum logic [2:0] {
        M_IDLE, M_NAME, M_NUMBER, M_STRING, M_ESCAPE, M_HEX1, M_HEX2, M_STOPPED
    } mode_t;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (is_digit(c)) r = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = 5'(c[3:0] + 4'd9);
        return r;
    endfunction

    // two-byte strtol base 16, low eight bits
    function automatic logic [7:0] hex_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] da;
        logic [4:0] db;
        logic [7:0] v;
        da = hex_val(a);
        db = hex_val(b);
        v  = 8'h00;
        if (is_space(a)) begin
            if (!db[4]) v = {4'h0, db[3:0]};
        end else if (a == CH_PLUS || a == CH_MINUS) begin
            if (!db[4]) v = {4'h0, db[3:0]};
            if (a == CH_MINUS) v = 8'h00 - v;
        end else if (!da[4]) begin
            v = {4'h0, da[3:0]};
            if (!db[4]) v = {da[3:0], db[3:0]};
        end
        return v;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  hex_reg, hex_next;
    logic [23:0] line_reg, line_next;

    logic        accept;
    logic [23:0] line_inc;
    logic        st_emit;
    logic        st_newline;
    mode_t       st_mode;
    tok_t        st_tok;
    logic        do_start;
    logic        start_second;
    tok_t        r0, r1;
    logic        two;

    assign accept   = in_valid && in_ready;
    assign line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + 24'd1;

    // what a byte does at the start of a token
    always_comb begin
        st_emit    = 1'b1;
        st_newline = 1'b0;
        st_mode    = M_IDLE;
        st_tok     = '{kind: KIND_ERROR, value: 32'd0, line: line_reg};
        if (in_byte == CH_NL) begin
            st_newline  = 1'b1;
            st_tok.kind = KIND_NEWLINE;
            st_tok.line = line_inc;
        end else if (is_space(in_byte)) begin
            st_emit = 1'b0;
        end else if (in_byte == CH_COLON) begin
            st_tok.kind = KIND_COLON;
        end else if (in_byte == CH_EQUALS) begin
            st_tok.kind = KIND_EQUALS;
        end else if (in_byte == CH_OPEN) begin
            st_tok.kind = KIND_OPEN;
        end else if (in_byte == CH_CLOSE) begin
            st_tok.kind = KIND_CLOSE;
        end else if (in_byte == CH_QUOTE) begin
            st_emit = 1'b0;
            st_mode = M_STRING;
        end else if (is_alpha(in_byte)) begin
            st_mode      = M_NAME;
            st_tok.kind  = KIND_NAME_CHAR;
            st_tok.value = {24'd0, in_byte};
        end else if (is_digit(in_byte)) begin
            st_emit = 1'b0;
            st_mode = M_NUMBER;
        end else begin
            st_mode = M_STOPPED;
        end
    end

    always_comb begin
        mode_next    = mode_reg;
        len_next     = len_reg;
        acc_next     = acc_reg;
        hex_next     = hex_reg;
        line_next    = line_reg;
        push         = 1'b0;
        two          = 1'b0;
        do_start     = 1'b0;
        start_second = 1'b0;
        r0 = '{kind: KIND_ERROR, value: 32'd0, line: line_reg};
        r1 = '{kind: KIND_END, value: 32'd0, line: line_reg};
        if (accept) begin
            case (mode_reg)
                M_IDLE: begin
                    if (in_eoi) begin
                        r0.kind   = KIND_END;
                        push      = 1'b1;
                        mode_next = M_STOPPED;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                M_NAME: begin
                    if (in_eoi) begin
                        r0.kind   = KIND_NAME_END;
                        two       = 1'b1;
                        push      = 1'b1;
                        mode_next = M_STOPPED;
                    end else if (is_alpha(in_byte) || is_digit(in_byte)
                                 || in_byte == CH_UNDER) begin
                        push = 1'b1;
                        if (len_reg >= LEN_W'(NAME_LIMIT)) begin
                            mode_next = M_STOPPED;
                        end else begin
                            len_next = len_reg + LEN_W'(1);
                            r0.kind  = KIND_NAME_CHAR;
                            r0.value = {24'd0, in_byte};
                        end
                    end else begin
                        r0.kind      = KIND_NAME_END;
                        push         = 1'b1;
                        do_start     = 1'b1;
                        start_second = 1'b1;
                    end
                end
                M_NUMBER: begin
                    r0.kind  = KIND_NUMBER;
                    r0.value = acc_reg;
                    if (in_eoi) begin
                        two       = 1'b1;
                        push      = 1'b1;
                        mode_next = M_STOPPED;
                    end else if (is_digit(in_byte)) begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1) + {28'd0, in_byte[3:0]};
                    end else begin
                        push         = 1'b1;
                        do_start     = 1'b1;
                        start_second = 1'b1;
                    end
                end
                M_STRING: begin
                    if (in_eoi || in_byte < CH_SPACE || in_byte > CH_TILDE) begin
                        push      = 1'b1;
                        mode_next = M_STOPPED;
                    end else if (in_byte == CH_QUOTE) begin
                        r0.kind   = KIND_STRING_END;
                        push      = 1'b1;
                        mode_next = M_IDLE;
                    end else if (in_byte == CH_BSLASH) begin
                        mode_next = M_ESCAPE;
                    end else begin
                        r0.kind  = KIND_STRING_CHAR;
                        r0.value = {24'd0, in_byte};
                        push     = 1'b1;
                    end
                end
                M_ESCAPE: begin
                    push = 1'b1;
                    if (in_eoi) begin
                        mode_next = M_STOPPED;
                    end else if (in_byte == CH_N) begin
                        r0.kind   = KIND_STRING_CHAR;
                        r0.value  = {24'd0, CH_NL};
                        mode_next = M_STRING;
                    end else if (in_byte == CH_BSLASH || in_byte == CH_QUOTE) begin
                        r0.kind   = KIND_STRING_CHAR;
                        r0.value  = {24'd0, in_byte};
                        mode_next = M_STRING;
                    end else if (in_byte == CH_X) begin
                        push      = 1'b0;
                        mode_next = M_HEX1;
                    end else begin
                        mode_next = M_STOPPED;
                    end
                end
                M_HEX1: begin
                    if (in_eoi) begin
                        push      = 1'b1;
                        mode_next = M_STOPPED;
                    end else begin
                        hex_next  = in_byte;
                        mode_next = M_HEX2;
                    end
                end
                M_HEX2: begin
                    push = 1'b1;
                    if (in_eoi) begin
                        mode_next = M_STOPPED;
                    end else begin
                        r0.kind   = KIND_STRING_CHAR;
                        r0.value  = {24'd0, hex_pair(hex_reg, in_byte)};
                        mode_next = M_STRING;
                    end
                end
                default: begin
                    mode_next = M_STOPPED;
                end
            endcase

            if (do_start) begin
                mode_next = st_mode;
                if (st_mode == M_NAME) len_next = LEN_W'(1);
                if (st_mode == M_NUMBER) acc_next = {28'd0, in_byte[3:0]};
                if (st_newline) line_next = line_inc;
                if (st_emit) begin
                    push = 1'b1;
                    if (start_second) begin
                        two = 1'b1;
                        r1  = st_tok;
                    end else begin
                        r0 = st_tok;
                    end
                end
            end
        end
    end

    assign push_bundle = '{two: two, first: r0, second: r1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            len_reg  <= '0;
            acc_reg  <= 32'd0;
            line_reg <= 24'd1;
        end else begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
            line_reg <= line_next;
        end
    end

    always_ff @(posedge aclk) begin
        hex_reg <= hex_next;
    end

    `ATT_ASSERT_NEXT(a_stop_sticks, mode_reg == M_STOPPED, mode_reg == M_STOPPED,
        "lexer left stopped mode")
    `ATT_ASSERT_NOW(a_push_on_accept, push, accept, "bundle pushed without a request")
    `ATT_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_W'(NAME_LIMIT), "name length overrun")
    `ATT_ASSERT_NOW(a_line_nonzero, 1'b1, line_reg != 24'd0, "line count wrapped to zero")

endmodule

@@ rtl/att_queue.sv @@
// Short bundle queue between the lexer and the result emitter.
// Depends on att_pkg.
`timescale 1ns / 1ps

module att_queue import att_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  bundle_t   push_bundle,
    input  logic      pop,
    output bundle_t   head,
    output q_status_t status
);

    bundle_t            entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign head         = entries[rd_ptr_reg];
    assign status.valid = count_reg != '0;
    assign status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)      count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push) count_reg <= count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entries[wr_ptr_reg] <= push_bundle;
    end

endmodule

@@ rtl/att_emitter.sv @@
// Back end: splits bundles into single results behind an output register.
// Depends on att_pkg and the tokenizer assertion macros.
`timescale 1ns / 1ps
`include "assembly_text_tokenizer_unit_defines.svh"

module att_emitter import att_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  bundle_t     head,
    input  q_status_t   q_status,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic [3:0]  m_tuser,
    output logic        m_tlast
);

    logic out_valid_reg, out_valid_next;
    logic pend_reg, pend_next;
    logic out_last_reg, out_last_next;
    tok_t out_tok_reg, out_tok_next;
    tok_t pend_tok_reg, pend_tok_next;
    logic load;

    assign load = !out_valid_reg || m_tready;
    assign pop  = load && !pend_reg && q_status.valid;

    always_comb begin
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        out_last_next  = out_last_reg;
        out_tok_next   = out_tok_reg;
        pend_tok_next  = pend_tok_reg;
        if (load) begin
            if (pend_reg) begin
                out_valid_next = 1'b1;
                out_tok_next   = pend_tok_reg;
                out_last_next  = 1'b1;
                pend_next      = 1'b0;
            end else if (q_status.valid) begin
                out_valid_next = 1'b1;
                out_tok_next   = head.first;
                out_last_next  = !head.two;
                pend_next      = head.two;
                pend_tok_next  = head.second;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_last_reg <= out_last_next;
        out_tok_reg  <= out_tok_next;
        pend_tok_reg <= pend_tok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_tok_reg.line, out_tok_reg.value};
    assign m_tuser  = out_tok_reg.kind;
    assign m_tlast  = out_last_reg;

    `ATT_ASSERT_NOW(a_pend_shown, pend_reg, out_valid_reg && !out_last_reg,
        "second token pending behind a last result")
    `ATT_ASSERT_NOW(a_notlast_pend, out_valid_reg && !out_last_reg, pend_reg,
        "non-last result without a follower")
    `ATT_ASSERT_NOW(a_pop_nonempty, pop, q_status.valid, "pop from empty queue")

endmodule

@@ tb/testbench.sv @@
// Testbench for assembly_text_tokenizer_unit: directed table, then random assembler-like text.
// A built-in lexer model predicts the tokens; stream handshakes idle and stall on both sides.
// Depends on att_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
    import att_pkg::*;

    localparam int RANDOM_REQUESTS   = 1750;
    localparam int HOLD_AFTER_TOKENS = 300;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT       = 3000;
    localparam int DRAIN_CYCLES      = 16;
    localparam int DIR_ROWS          = 25;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        LX_IDLE, LX_NAME, LX_NUMBER, LX_STRING, LX_ESCAPE, LX_HEX1, LX_HEX2, LX_STOPPED
    } lex_mode_t;

    typedef enum int {
        STOP_EOI_IDLE, STOP_EOI_NAME, STOP_EOI_NUMBER, STOP_EOI_STRING, STOP_EOI_ESCAPE,
        STOP_EOI_HEX, STOP_BAD_START, STOP_LONG_NAME, STOP_BAD_STRING_BYTE, STOP_BAD_ESCAPE
    } stop_case_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [23:0] line;
        logic        last;
    } token_rec_t;

    // kind/value/line only count when typed is set
    typedef struct packed {
        logic [7:0]  data;
        logic        eoi;
        logic        typed;
        kind_t       kind;
        logic [31:0] value;
        logic [23:0] line;
    } request_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] byte_in
    logic        s_tuser;   // [0] end_of_input
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [31:0] token_value, [55:32] line_number
    logic [3:0]  m_tuser;   // [3:0] token_kind
    logic        m_tlast;

    request_row_t directed_rows [DIR_ROWS] = '{
        '{":",       1'b0, 1'b1, KIND_COLON,       32'd0,   24'd1},
        '{"=",       1'b0, 1'b1, KIND_EQUALS,      32'd0,   24'd1},
        '{"(",       1'b0, 1'b1, KIND_OPEN,        32'd0,   24'd1},
        '{")",       1'b0, 1'b1, KIND_CLOSE,       32'd0,   24'd1},
        '{CH_NL,     1'b0, 1'b1, KIND_NEWLINE,     32'd0,   24'd2},
        '{CH_CR,     1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{"Z",       1'b0, 1'b1, KIND_NAME_CHAR,   32'd90,  24'd2},
        '{"_",       1'b0, 1'b1, KIND_NAME_CHAR,   32'd95,  24'd2},
        '{"0",       1'b0, 1'b1, KIND_NAME_CHAR,   32'd48,  24'd2},
        '{"z",       1'b0, 1'b1, KIND_NAME_CHAR,   32'd122, 24'd2},
        '{CH_TAB,    1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{"9",       1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{"9",       1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{"(",       1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{8'h7E,     1'b0, 1'b1, KIND_STRING_CHAR, 32'd126, 24'd2},
        '{CH_SPACE,  1'b0, 1'b1, KIND_STRING_CHAR, 32'd32,  24'd2},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{"x",       1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{8'hFF,     1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{8'h80,     1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0},
        '{"n",       1'b0, 1'b1, KIND_STRING_CHAR, 32'd10,  24'd2},
        '{CH_QUOTE,  1'b0, 1'b1, KIND_STRING_END,  32'd0,   24'd2},
        '{CH_VT,     1'b0, 1'b0, KIND_NAME_CHAR,   32'd0,   24'd0}
    };

    request_row_t stim [$];
    token_rec_t   pending_tokens [$];
    token_rec_t   item_tokens [$];
    int           accept_idx  = 0;
    int           pause_idx   = 0;
    int           idle_cycles = 0;
    int           fail_count  = 0;

    lex_mode_t    lx_mode      = LX_IDLE;
    int unsigned  lx_name_len  = 0;
    logic [31:0]  lx_number    = '0;
    logic [7:0]   lx_hex_first = '0;
    logic [23:0]  lx_line      = 24'd1;

    assembly_text_tokenizer_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // ---------------- lexer model ----------------

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int hex_val(logic [7:0] c);
        if (is_digit(c)) return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return 16;
    endfunction

    // strtol base 16 over two bytes: one leading blank, optional sign, hex digits
    function automatic logic [7:0] hex_pair_char(logic [7:0] a, logic [7:0] b);
        logic [7:0]  s [2];
        int          i;
        logic [31:0] v;
        bit          neg;
        s[0] = a;
        s[1] = b;
        i = 0;
        v = '0;
        neg = 1'b0;
        if (is_blank(s[0])) i = 1;
        if (i < 2 && (s[i] == "+" || s[i] == "-")) begin
            neg = (s[i] == "-");
            i++;
        end
        while (i < 2 && hex_val(s[i]) < 16) begin
            v = v * 32'd16 + 32'(hex_val(s[i]));
            i++;
        end
        if (neg) v = -v;
        return v[7:0];
    endfunction

    function automatic void add_token(kind_t k, logic [31:0] v);
        token_rec_t t;
        t.kind  = k;
        t.value = v;
        t.line  = lx_line;
        t.last  = 1'b0;
        item_tokens.push_back(t);
    endfunction

    function automatic void stop_on_error();
        add_token(KIND_ERROR, '0);
        lx_mode = LX_STOPPED;
    endfunction

    function automatic void open_token(logic [7:0] c);
        lx_mode = LX_IDLE;
        if (c == CH_NL) begin
            if (lx_line != LINE_MAX) lx_line++;
            add_token(KIND_NEWLINE, '0);
        end else if (is_blank(c)) begin
        end else if (c == ":") begin
            add_token(KIND_COLON, '0);
        end else if (c == "=") begin
            add_token(KIND_EQUALS, '0);
        end else if (c == "(") begin
            add_token(KIND_OPEN, '0);
        end else if (c == ")") begin
            add_token(KIND_CLOSE, '0);
        end else if (c == CH_QUOTE) begin
            lx_mode = LX_STRING;
        end else if (is_alpha(c)) begin
            lx_mode = LX_NAME;
            lx_name_len = 1;
            add_token(KIND_NAME_CHAR, {24'd0, c});
        end else if (is_digit(c)) begin
            lx_mode = LX_NUMBER;
            lx_number = {24'd0, c - "0"};
        end else begin
            stop_on_error();
        end
    endfunction

    // tokens caused by one request land in item_tokens
    function automatic void tokenize_byte(logic [7:0] c, logic eoi);
        item_tokens.delete();
        case (lx_mode)
            LX_IDLE: begin
                if (eoi) begin
                    add_token(KIND_END, '0);
                    lx_mode = LX_STOPPED;
                end else begin
                    open_token(c);
                end
            end
            LX_NAME: begin
                if (eoi) begin
                    add_token(KIND_NAME_END, '0);
                    add_token(KIND_END, '0);
                    lx_mode = LX_STOPPED;
                end else if (is_alpha(c) || is_digit(c) || c == "_") begin
                    if (lx_name_len >= NAME_LIMIT) begin
                        stop_on_error();
                    end else begin
                        lx_name_len++;
                        add_token(KIND_NAME_CHAR, {24'd0, c});
                    end
                end else begin
                    add_token(KIND_NAME_END, '0);
                    open_token(c);
                end
            end
            LX_NUMBER: begin
                if (eoi) begin
                    add_token(KIND_NUMBER, lx_number);
                    add_token(KIND_END, '0);
                    lx_mode = LX_STOPPED;
                end else if (is_digit(c)) begin
                    lx_number = lx_number * 32'd10 + {24'd0, c - "0"};
                end else begin
                    add_token(KIND_NUMBER, lx_number);
                    open_token(c);
                end
            end
            LX_STRING: begin
                if (eoi || c < 8'h20 || c > 8'h7E) begin
                    stop_on_error();
                end else if (c == CH_QUOTE) begin
                    add_token(KIND_STRING_END, '0);
                    lx_mode = LX_IDLE;
                end else if (c == CH_BSLASH) begin
                    lx_mode = LX_ESCAPE;
                end else begin
                    add_token(KIND_STRING_CHAR, {24'd0, c});
                end
            end
            LX_ESCAPE: begin
                if (eoi) begin
                    stop_on_error();
                end else if (c == "n") begin
                    add_token(KIND_STRING_CHAR, {24'd0, CH_NL});
                    lx_mode = LX_STRING;
                end else if (c == CH_BSLASH || c == CH_QUOTE) begin
                    add_token(KIND_STRING_CHAR, {24'd0, c});
                    lx_mode = LX_STRING;
                end else if (c == "x") begin
                    lx_mode = LX_HEX1;
                end else begin
                    stop_on_error();
                end
            end
            LX_HEX1: begin
                if (eoi) begin
                    stop_on_error();
                end else begin
                    lx_hex_first = c;
                    lx_mode = LX_HEX2;
                end
            end
            LX_HEX2: begin
                if (eoi) begin
                    stop_on_error();
                end else begin
                    add_token(KIND_STRING_CHAR, {24'd0, hex_pair_char(lx_hex_first, c)});
                    lx_mode = LX_STRING;
                end
            end
            default: lx_mode = LX_STOPPED;
        endcase
    endfunction

    // ---------------- stimulus ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        request_row_t row;
        row = '0;
        row.data = b;
        stim.push_back(row);
    endfunction

    function automatic void add_eoi();
        request_row_t row;
        row = '0;
        row.data = 8'($urandom_range(0, 255));
        row.eoi = 1'b1;
        stim.push_back(row);
    endfunction

    function automatic logic [7:0] pick_name_char(bit alpha_only);
        int r;
        r = alpha_only ? $urandom_range(0, 51) : $urandom_range(0, 62);
        if (r < 26) return 8'(r) + "a";
        if (r < 52) return 8'(r - 26) + "A";
        if (r < 62) return 8'(r - 52) + "0";
        return "_";
    endfunction

    function automatic void emit_name(int len);
        add_byte(pick_name_char(1'b1));
        for (int i = 1; i < len; i++) add_byte(pick_name_char(1'b0));
    endfunction

    function automatic void emit_number(int ndig);
        for (int i = 0; i < ndig; i++) add_byte(8'($urandom_range(0, 9)) + "0");
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 9))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_NL;
            3: return ":";
            4: return "=";
            5: return "(";
            6: return ")";
            7: return CH_VT;
            8: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_hex_arg();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            r = $urandom_range(0, 21);
            if (r < 10) return 8'(r) + "0";
            if (r < 16) return 8'(r - 10) + "a";
            return 8'(r - 16) + "A";
        end
        if (r == 4) return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
        if (r == 5) return "+";
        if (r == 6) return "-";
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void build_stimulus();
        int         r;
        int         n;
        logic [7:0] b;
        stop_case_t stop_case;
        foreach (directed_rows[i]) stim.push_back(directed_rows[i]);
        pause_idx = DIR_ROWS + RANDOM_REQUESTS / 2;
        while (stim.size() < DIR_ROWS + RANDOM_REQUESTS) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                r = $urandom_range(0, 99);
                if (r < 10) n = NAME_LIMIT;
                else if (r < 25) n = $urandom_range(9, NAME_LIMIT - 1);
                else n = $urandom_range(1, 8);
                emit_name(n);
                add_byte(pick_separator());
            end else if (r < 48) begin
                emit_number($urandom_range(0, 4) == 0 ? $urandom_range(5, 20)
                                                       : $urandom_range(1, 4));
                add_byte(pick_separator());
            end else if (r < 62) begin
                add_byte(CH_QUOTE);
                n = $urandom_range(0, 10);
                for (int j = 0; j < n; j++) begin
                    if ($urandom_range(0, 9) < 7) begin
                        do b = 8'($urandom_range(32, 126));
                        while (b == CH_QUOTE || b == CH_BSLASH);
                        add_byte(b);
                    end else begin
                        add_byte(CH_BSLASH);
                        case ($urandom_range(0, 3))
                            0: add_byte("n");
                            1: add_byte(CH_BSLASH);
                            2: add_byte(CH_QUOTE);
                            default: begin
                                add_byte("x");
                                add_byte(pick_hex_arg());
                                add_byte(pick_hex_arg());
                            end
                        endcase
                    end
                end
                add_byte(CH_QUOTE);
            end else if (r < 72) begin
                add_byte(CH_NL);
            end else begin
                add_byte(pick_separator());
            end
        end

        // one terminating event per run; the seed picks which
        stop_case = stop_case_t'($urandom_range(0, int'(STOP_BAD_ESCAPE)));
        case (stop_case)
            STOP_EOI_IDLE: add_eoi();
            STOP_EOI_NAME: begin
                emit_name($urandom_range(1, 5));
                add_eoi();
            end
            STOP_EOI_NUMBER: begin
                emit_number($urandom_range(1, 12));
                add_eoi();
            end
            STOP_EOI_STRING: begin
                add_byte(CH_QUOTE);
                add_byte("a");
                add_eoi();
            end
            STOP_EOI_ESCAPE: begin
                add_byte(CH_QUOTE);
                add_byte(CH_BSLASH);
                add_eoi();
            end
            STOP_EOI_HEX: begin
                add_byte(CH_QUOTE);
                add_byte(CH_BSLASH);
                add_byte("x");
                if ($urandom_range(0, 1)) add_byte(8'($urandom_range(0, 255)));
                add_eoi();
            end
            STOP_BAD_START: begin
                do b = 8'($urandom_range(0, 255));
                while (is_alpha(b) || is_digit(b) || is_blank(b) || b == ":" || b == "="
                       || b == "(" || b == ")" || b == CH_QUOTE);
                add_byte(b);
            end
            STOP_LONG_NAME: emit_name(NAME_LIMIT + 1);
            STOP_BAD_STRING_BYTE: begin
                add_byte(CH_QUOTE);
                add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                              : 8'($urandom_range(127, 255)));
            end
            default: begin
                add_byte(CH_QUOTE);
                add_byte(CH_BSLASH);
                do b = 8'($urandom_range(0, 255));
                while (b == "n" || b == "x" || b == CH_BSLASH || b == CH_QUOTE);
                add_byte(b);
            end
        endcase

        // block is stopped now: these must be swallowed silently
        n = $urandom_range(4, 12);
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 1)) add_eoi();
            else add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // ---------------- request side ----------------

    initial begin : request_driver
        int gap;
        bit tx_calm;
        tx_calm = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        build_stimulus();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        for (int k = 0; k < stim.size(); k++) begin
            if (k % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            gap = tx_calm ? 0 : pick_gap();
            if (gap > 0 || k == pause_idx) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
                if (k == pause_idx) begin
                    @(posedge aclk);
                    while (pending_tokens.size() != 0) @(posedge aclk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= stim[k].data;
            s_tuser  <= stim[k].eoi;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // ---------------- result side: predict, check, drive m_tready ----------------

    initial begin : port_monitor
        request_row_t cur;
        token_rec_t   t;
        token_rec_t   want;
        bit           took;
        bit           rx_calm;
        int           stall;
        int           seen;
        rx_calm = 1'b0;
        stall = 0;
        seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            took = 1'b0;
            if (aresetn && s_tvalid && s_tready) begin
                cur = stim[accept_idx];
                accept_idx++;
                tokenize_byte(cur.data, cur.eoi);
                if (cur.typed) begin
                    t.kind  = cur.kind;
                    t.value = cur.value;
                    t.line  = cur.line;
                    t.last  = 1'b1;
                    pending_tokens.push_back(t);
                end else begin
                    foreach (item_tokens[i]) begin
                        t = item_tokens[i];
                        t.last = (i == item_tokens.size() - 1);
                        pending_tokens.push_back(t);
                    end
                end
            end
            if (aresetn && m_tvalid && m_tready) begin
                took = 1'b1;
                if (pending_tokens.size() == 0) begin
                    $error("unexpected token: kind %0d value %0h line %0d",
                           m_tuser, m_tdata[31:0], m_tdata[55:32]);
                    fail_count++;
                end else begin
                    want = pending_tokens.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== want.value) begin
                        $error("token_value: expected %0h, got %0h", want.value, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[55:32] !== want.line) begin
                        $error("line_number: expected %0d, got %0d", want.line, m_tdata[55:32]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (took || (aresetn && s_tvalid && s_tready)) idle_cycles = 0;
            else idle_cycles++;

            // one long hold while requests keep coming, so the queue fills up
            if (took) begin
                seen++;
                if (seen % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
                if (seen == HOLD_AFTER_TOKENS) stall = LONG_HOLD_CYCLES;
                else if (!rx_calm) stall = pick_gap();
            end else if (stall == 0 && !rx_calm && $urandom_range(0, 7) == 0) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        do @(posedge aclk);
        while (idle_cycles < STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/att_pkg.sv
rtl/att_lexer.sv
rtl/att_queue.sv
rtl/att_emitter.sv
rtl/assembly_text_tokenizer_unit.sv
tb/testbench.sv
